FILE: rtl/pts_pkg.sv
// Package for the PDU transmit scheduler: register indexes, op and mode codes,
// reset values and sizing constants.
// No dependencies.
`default_nettype none

package pts_pkg;

  // Item operations
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Transmission modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_DIRECT   = 2'd2;
  localparam logic [1:0] MODE_MIXED    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_TX_MODE          = 3'd0;
  localparam logic [2:0] REG_PERIOD_MS        = 3'd1;
  localparam logic [2:0] REG_TICK_MS          = 3'd2;
  localparam logic [2:0] REG_STARTUP_TICKS    = 3'd3;
  localparam logic [2:0] REG_FRAME_LEN        = 3'd4;
  localparam logic [2:0] REG_HEADER_PROTECTED = 3'd5;
  localparam logic [2:0] REG_STUCK_LIMIT_MS   = 3'd6;

  // Register reset values
  localparam logic [7:0]  TICK_MS_RST       = 8'd10;
  localparam logic [15:0] STARTUP_TICKS_RST = 16'd50;
  localparam logic [3:0]  FRAME_LEN_RST     = 4'd8;
  localparam logic [15:0] STUCK_LIMIT_RST   = 16'd100;

  // Sizing
  localparam int FRAME_BYTES_DEF = 8;   // frame size in bytes
  localparam int DATA_CAP        = 8;   // most bytes ever sent or compared
  localparam logic [3:0] HEADER_SKIP = 4'd2;
  localparam logic [15:0] SIZE_MAX_MASK = 16'hFFFF;

endpackage

`default_nettype wire

FILE: rtl/pdu_tx_scheduler_core.sv
// PDU transmit scheduler: signal packing into the frame buffer, transmit mode
// rules, change suppression and stuck detection, in one pass per word.
// Depends on pts_pkg.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_ready      op .. link_ready
//  result    out        result_valid / result_ready  sent .. pending_now
//  config    in         cfg_we (no wait)             cfg_index, cfg_data
//
// One word per cycle sustained while result_ready stays high; a word shows up as a
// result after it is accepted by way of the input register, then the result register.
// All state is updated in the single cycle where a word moves from the input
// register into the result register, so the next word sees it at once.
// rst (synchronous) clears state and loads the register reset values.
// While result_ready is low the result holds and one more word can wait in
// the input register.
`default_nettype none

module pdu_tx_scheduler_core
  import pts_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // item channel
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  bit_pos,
  input  wire logic [4:0]  sig_width,
  input  wire logic [15:0] sig_value,
  input  wire logic        update_enable,
  input  wire logic [5:0]  update_bit_pos,
  input  wire logic        link_ready,
  // result channel
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             sent,
  output logic [63:0]      frame_data,
  output logic [3:0]       frame_bytes,
  output logic             stuck,
  output logic             throttled,
  output logic             pending_now
);

  // Only the first bytes up to the send cap are ever read back
  localparam int STORE = (FRAME_BYTES < DATA_CAP) ? FRAME_BYTES : DATA_CAP;
  localparam logic [6:0] FB_LIM    = 7'(FRAME_BYTES);
  localparam logic [3:0] STORE_LEN = 4'(STORE);

  // Configuration registers
  logic [1:0]  tx_mode;
  logic [15:0] period_ms;
  logic [7:0]  tick_ms;
  logic [15:0] startup_ticks;
  logic [3:0]  frame_len;
  logic        header_protected;
  logic [15:0] stuck_limit_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_mode          <= MODE_NONE;
      period_ms        <= '0;
      tick_ms          <= TICK_MS_RST;
      startup_ticks    <= STARTUP_TICKS_RST;
      frame_len        <= FRAME_LEN_RST;
      header_protected <= 1'b0;
      stuck_limit_ms   <= STUCK_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TX_MODE:          tx_mode          <= cfg_data[1:0];
        REG_PERIOD_MS:        period_ms        <= cfg_data;
        REG_TICK_MS:          tick_ms          <= cfg_data[7:0];
        REG_STARTUP_TICKS:    startup_ticks    <= cfg_data;
        REG_FRAME_LEN:        frame_len        <= cfg_data[3:0];
        REG_HEADER_PROTECTED: header_protected <= cfg_data[0];
        REG_STUCK_LIMIT_MS:   stuck_limit_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [5:0]  s1_pos;
  logic [4:0]  s1_size;
  logic [15:0] s1_value;
  logic        s1_upd;
  logic [5:0]  s1_upos;
  logic        s1_link;
  logic        s1_go;

  assign s1_go      = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_op    <= op;
      s1_pos   <= bit_pos;
      s1_size  <= sig_width;
      s1_value <= sig_value;
      s1_upd   <= update_enable;
      s1_upos  <= update_bit_pos;
      s1_link  <= link_ready;
    end
  end

  // Scheduler state
  logic [7:0]  frame_buf     [STORE];
  logic [7:0]  last_sent_buf [STORE];
  logic        pending;
  logic        ever_sent;
  logic [15:0] period_count;
  logic [15:0] fail_time;
  logic [15:0] startup_count;

  logic [7:0]  frame_buf_next [STORE];
  logic [7:0]  packed_buf     [STORE];
  logic        pending_next;
  logic        ever_sent_next;
  logic [15:0] period_count_next;
  logic [15:0] fail_time_next;
  logic [15:0] startup_count_next;
  logic        do_send;
  logic        r_stuck;
  logic        r_throttled;

  // Signal packing into a two-byte window
  logic [4:0]  size_c;
  logic [15:0] mask;
  logic [15:0] val;
  logic [2:0]  sh;
  logic [2:0]  off;
  logic [3:0]  off_p1;
  logic [15:0] sm;
  logic [15:0] sv;
  logic        single;
  logic        write_ok;
  logic        upd_ok;
  logic [5:0]  span;

  always_comb begin
    size_c   = (s1_size > 5'd16) ? 5'd16 : s1_size;
    mask     = (size_c == 5'd16) ? SIZE_MAX_MASK : ((16'd1 << size_c) - 16'd1);
    val      = s1_value & mask;
    sh       = s1_pos[2:0];
    off      = s1_pos[5:3];
    off_p1   = {1'b0, off} + 4'd1;
    sm       = mask << sh;
    sv       = val << sh;
    span     = {1'b0, size_c} + {3'b0, sh};
    single   = span <= 6'd8;
    write_ok = single ? ({4'b0, off} < FB_LIM) : ({3'b0, off_p1} < FB_LIM);
    upd_ok   = s1_upd && ({4'b0, s1_upos[5:3]} < FB_LIM);
    for (int k = 0; k < STORE; k++) begin
      packed_buf[k] = frame_buf[k];
      if (write_ok && off == 3'(k)) begin
        packed_buf[k] = (frame_buf[k] & ~sm[7:0]) | sv[7:0];
      end
      if (write_ok && off_p1 == 4'(k)) begin
        packed_buf[k] = (frame_buf[k] & ~sm[15:8]) | sv[15:8];
      end
      if (upd_ok && s1_upos[5:3] == 3'(k)) begin
        packed_buf[k] = packed_buf[k] | (8'd1 << s1_upos[2:0]);
      end
    end
  end

  // Effective length and change compare against the last sent frame
  logic [3:0] eff_len;
  logic [3:0] skip;
  logic       changed;

  always_comb begin
    eff_len = (frame_len > STORE_LEN) ? STORE_LEN : frame_len;
    skip    = header_protected ? HEADER_SKIP : 4'd0;
    changed = 1'b0;
    for (int k = 0; k < STORE; k++) begin
      if (4'(k) >= skip && 4'(k) < eff_len && frame_buf[k] != last_sent_buf[k]) begin
        changed = 1'b1;
      end
    end
  end

  // Mode rules for one word
  logic [16:0] pc_sum;
  logic [15:0] pc_sat;
  logic [16:0] fail_sum;
  logic        go;
  logic        mode_tick;
  logic        mode_direct;

  always_comb begin
    frame_buf_next     = frame_buf;
    pending_next       = pending;
    ever_sent_next     = ever_sent;
    period_count_next  = period_count;
    fail_time_next     = fail_time;
    startup_count_next = startup_count;
    do_send            = 1'b0;
    r_stuck            = 1'b0;
    r_throttled        = 1'b0;
    go                 = 1'b0;

    mode_tick   = (tx_mode == MODE_PERIODIC) || (tx_mode == MODE_MIXED);
    mode_direct = (tx_mode == MODE_DIRECT) || (tx_mode == MODE_MIXED);
    pc_sum      = {1'b0, period_count} + {9'b0, tick_ms};
    pc_sat      = pc_sum[16] ? 16'hFFFF : pc_sum[15:0];
    fail_sum    = {1'b0, fail_time} + {9'b0, tick_ms};

    case (s1_op)
      OP_WRITE: begin
        frame_buf_next = packed_buf;
        pending_next   = 1'b1;
        if (mode_direct && s1_link) begin
          do_send = 1'b1;
        end
      end
      OP_FLUSH: begin
        pending_next = 1'b1;
      end
      OP_TICK: begin
        if (startup_count < startup_ticks) begin
          startup_count_next = startup_count + 16'd1;
        end else if (mode_tick) begin
          period_count_next = pc_sat;
          if (period_ms == 16'd0) begin
            go = pending;
          end else if (pc_sat >= period_ms && (tx_mode == MODE_PERIODIC || pending)) begin
            go                = 1'b1;
            period_count_next = '0;
          end
          // unchanged payload drops an event send and consumes pending
          if (go && ever_sent && period_ms == 16'd0 && !changed) begin
            go           = 1'b0;
            pending_next = 1'b0;
          end
          if (go) begin
            if (s1_link) begin
              do_send = 1'b1;
            end else if (fail_sum >= {1'b0, stuck_limit_ms}) begin
              r_stuck        = 1'b1;
              fail_time_next = '0;
            end else begin
              fail_time_next = fail_sum[15:0];
            end
          end else begin
            r_throttled = pending_next;
          end
        end
      end
      default: ;
    endcase

    if (do_send) begin
      pending_next   = 1'b0;
      fail_time_next = '0;
      ever_sent_next = 1'b1;
    end
  end

  // Frame handed to the link
  logic [63:0] send_data;

  always_comb begin
    send_data = '0;
    for (int k = 0; k < STORE; k++) begin
      if (4'(k) < eff_len) begin
        send_data[8*k +: 8] = frame_buf_next[k];
      end
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STORE; k++) begin
        frame_buf[k]     <= '0;
        last_sent_buf[k] <= '0;
      end
      pending       <= 1'b0;
      ever_sent     <= 1'b0;
      period_count  <= '0;
      fail_time     <= '0;
      startup_count <= '0;
    end else if (s1_go) begin
      frame_buf     <= frame_buf_next;
      pending       <= pending_next;
      ever_sent     <= ever_sent_next;
      period_count  <= period_count_next;
      fail_time     <= fail_time_next;
      startup_count <= startup_count_next;
      if (do_send) begin
        for (int k = 0; k < STORE; k++) begin
          if (4'(k) < eff_len) begin
            last_sent_buf[k] <= frame_buf_next[k];
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      sent        <= do_send;
      frame_data  <= do_send ? send_data : 64'd0;
      frame_bytes <= do_send ? eff_len : 4'd0;
      stuck       <= r_stuck;
      throttled   <= r_throttled;
      pending_now <= pending_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/pdu_tx_scheduler_core_tb.sv
// Testbench for pdu_tx_scheduler_core: a directed table, then randomized phases
// under changing register settings, each result checked by the predictor or a table row.
// Depends on pts_pkg and rtl/pdu_tx_scheduler_core.sv.
`timescale 1ns / 1ps

module pdu_tx_scheduler_core_tb;
  import pts_pkg::*;

  localparam int NBYTES = FRAME_BYTES_DEF;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int NUM_PHASES = 14;
  localparam int WORDS_PER_PHASE = 125;
  localparam int HOLD_AT = 600;       // result count at which the long hold starts
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  bit_pos;
    logic [4:0]  sig_width;
    logic [15:0] sig_value;
    logic        update_enable;
    logic [5:0]  update_bit_pos;
    logic        link_ready;
  } item_t;

  typedef struct packed {
    logic        sent;
    logic [63:0] frame_data;
    logic [3:0]  frame_bytes;
    logic        stuck;
    logic        throttled;
    logic        pending_now;
  } res_t;

  typedef struct {
    bit          is_reg;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    item_t       w;
    bit          typed;
    logic        exp_pending;
  } plan_row_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  op;
  logic [5:0]  bit_pos;
  logic [4:0]  sig_width;
  logic [15:0] sig_value;
  logic        update_enable;
  logic [5:0]  update_bit_pos;
  logic        link_ready;
  logic        result_valid;
  logic        result_ready;
  logic        sent;
  logic [63:0] frame_data;
  logic [3:0]  frame_bytes;
  logic        stuck;
  logic        throttled;
  logic        pending_now;

  // Predictor copy of registers and state
  logic [1:0]  m_mode;
  logic [15:0] m_cycle;
  logic [7:0]  m_tick;
  logic [15:0] m_startup;
  logic [3:0]  m_len;
  logic        m_hdr;
  logic [15:0] m_stuck;
  logic [7:0]  fbuf [NBYTES];
  logic [7:0]  lbuf [NBYTES];
  bit          pend, ever;
  int unsigned pcount, ftime, scount;

  res_t        results_due [$];
  plan_row_t   plan [$];
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          mismatches = 0;
  int          words_in = 0;
  int          results_seen = 0;
  int          n_sent = 0, n_stuck = 0, n_throttled = 0;

  pdu_tx_scheduler_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready),
    .op(op), .bit_pos(bit_pos), .sig_width(sig_width), .sig_value(sig_value),
    .update_enable(update_enable), .update_bit_pos(update_bit_pos),
    .link_ready(link_ready),
    .result_valid(result_valid), .result_ready(result_ready),
    .sent(sent), .frame_data(frame_data), .frame_bytes(frame_bytes),
    .stuck(stuck), .throttled(throttled), .pending_now(pending_now)
  );

  always #5 clk = ~clk;

  // Run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("[pdu_tx_scheduler_core] ERROR");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic void reset_state();
    m_mode = MODE_NONE; m_cycle = '0; m_tick = TICK_MS_RST;
    m_startup = STARTUP_TICKS_RST; m_len = FRAME_LEN_RST; m_hdr = 1'b0;
    m_stuck = STUCK_LIMIT_RST;
    for (int k = 0; k < NBYTES; k++) begin
      fbuf[k] = '0;
      lbuf[k] = '0;
    end
    pend = 0; ever = 0; pcount = 0; ftime = 0; scount = 0;
  endfunction

  // Bytes sent and compared
  function automatic int unsigned frame_span();
    int unsigned n;
    n = m_len;
    if (n > DATA_CAP) n = DATA_CAP;
    if (n > NBYTES) n = NBYTES;
    return n;
  endfunction

  // Link accepts the frame: snapshot it and clear pending and fail time
  function automatic void hand_off(input bit ready, inout res_t r);
    int unsigned n;
    if (!ready) return;
    n = frame_span();
    for (int k = 0; k < n; k++) begin
      r.frame_data[8*k +: 8] = fbuf[k];
      lbuf[k] = fbuf[k];
    end
    pend = 0; ftime = 0; ever = 1;
    r.sent = 1'b1;
    r.frame_bytes = n[3:0];
  endfunction

  function automatic res_t schedule_item(item_t w);
    res_t r;
    int unsigned off, sh, sz, msk, v, sm, sv, raw, t, n, k;
    bit go, changed;
    r = '0;
    case (w.op)
      OP_WRITE: begin
        off = w.bit_pos[5:3];
        sh = w.bit_pos[2:0];
        sz = (w.sig_width > 16) ? 16 : w.sig_width;
        msk = (32'd1 << sz) - 1;
        v = w.sig_value & msk;
        if (sz + sh <= 8) begin
          if (off < NBYTES) begin
            raw = (fbuf[off] & ~(msk << sh)) | (v << sh);
            fbuf[off] = raw[7:0];
          end
        end else if (off + 1 < NBYTES) begin
          sm = (msk << sh) & 32'hFFFF;
          sv = (v << sh) & 32'hFFFF;
          raw = {fbuf[off+1], fbuf[off]};
          raw = (raw & ~sm) | sv;
          fbuf[off] = raw[7:0];
          fbuf[off+1] = raw[15:8];
        end
        pend = 1;
        if (w.update_enable && w.update_bit_pos[5:3] < NBYTES)
          fbuf[w.update_bit_pos[5:3]][w.update_bit_pos[2:0]] = 1'b1;
        if (m_mode == MODE_DIRECT || m_mode == MODE_MIXED)
          hand_off(w.link_ready, r);
      end
      OP_FLUSH: pend = 1;
      OP_TICK: begin
        if (scount < m_startup) begin
          scount++;
        end else if (m_mode == MODE_PERIODIC || m_mode == MODE_MIXED) begin
          go = 0;
          pcount += m_tick;
          if (pcount > 32'hFFFF) pcount = 32'hFFFF;
          if (m_cycle == 0) begin
            go = pend;
          end else if (pcount >= m_cycle && (m_mode == MODE_PERIODIC || pend)) begin
            go = 1;
            pcount = 0;
          end
          // event send with unchanged payload is dropped
          if (go && ever) begin
            changed = 0;
            n = frame_span();
            for (k = m_hdr ? HEADER_SKIP : 0; k < n; k++)
              if (fbuf[k] != lbuf[k]) changed = 1;
            if (m_cycle == 0 && !changed) begin
              go = 0;
              pend = 0;
            end
          end
          if (go) begin
            hand_off(w.link_ready, r);
            if (!r.sent) begin
              t = ftime + m_tick;
              if (t >= m_stuck) begin
                r.stuck = 1'b1;
                t = 0;
              end
              ftime = t & 32'hFFFF;
            end
          end else begin
            r.throttled = pend;
          end
        end
      end
      default: ;
    endcase
    r.pending_now = pend;
    return r;
  endfunction

  // ---------------- drivers ----------------

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_TX_MODE:          m_mode = val[1:0];
      REG_PERIOD_MS:        m_cycle = val;
      REG_TICK_MS:          m_tick = val[7:0];
      REG_STARTUP_TICKS:    m_startup = val;
      REG_FRAME_LEN:        m_len = val[3:0];
      REG_HEADER_PROTECTED: m_hdr = val[0];
      REG_STUCK_LIMIT_MS:   m_stuck = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait until every outstanding word has come back and the pipe is empty
  task automatic drain();
    item_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_regs(input logic [1:0] mode, input logic [15:0] cyc,
                          input logic [7:0] tick, input logic [15:0] start,
                          input logic [3:0] len, input logic hdr,
                          input logic [15:0] lim);
    drain();
    write_reg(REG_TX_MODE, mode);
    write_reg(REG_PERIOD_MS, cyc);
    write_reg(REG_TICK_MS, tick);
    write_reg(REG_STARTUP_TICKS, start);
    write_reg(REG_FRAME_LEN, len);
    write_reg(REG_HEADER_PROTECTED, hdr);
    write_reg(REG_STUCK_LIMIT_MS, lim);
  endtask

  // Offer one word; called and returns at a falling edge
  task automatic offer_word(input item_t w, input bit typed, input res_t typed_res);
    int gap;
    res_t r;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = w.op;
    bit_pos = w.bit_pos;
    sig_width = w.sig_width;
    sig_value = w.sig_value;
    update_enable = w.update_enable;
    update_bit_pos = w.update_bit_pos;
    link_ready = w.link_ready;
    item_valid = 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    r = schedule_item(w);
    results_due.push_back(typed ? typed_res : r);
    words_in++;
    @(negedge clk);
  endtask

  function automatic res_t idle_res(input logic p);
    res_t r;
    r = '0;
    r.pending_now = p;
    return r;
  endfunction

  function automatic void plan_cfg(input logic [2:0] idx, input logic [15:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  function automatic void plan_word(input logic [1:0] o, input logic [5:0] pos,
                                    input logic [4:0] sz, input logic [15:0] val,
                                    input logic upd, input logic [5:0] upos,
                                    input logic rdy, input bit typed,
                                    input logic exp_p);
    plan_row_t row;
    row = '{default: '0};
    row.w = '{o, pos, sz, val, upd, upos, rdy};
    row.typed = typed;
    row.exp_pending = exp_p;
    plan.push_back(row);
  endfunction

  function automatic void build_plan();
    // reset settings: no mode, still in startup
    plan_word(OP_WRITE,   0, 16, 16'hFFFF, 0, 0, 1, 1, 1);
    plan_word(OP_TICK,    0,  0, 16'h0000, 0, 0, 1, 1, 1);
    plan_word(OP_UNKNOWN, 0,  0, 16'h0000, 0, 0, 1, 1, 1);
    plan_word(OP_FLUSH,   0,  0, 16'h0000, 0, 0, 1, 1, 1);
    // direct: out-of-frame span, zero size with refused link, oversize, two-byte span
    plan_cfg(REG_TX_MODE, MODE_DIRECT);
    plan_word(OP_WRITE, 63, 16, 16'hFFFF, 1, 63, 1, 0, 0);
    plan_word(OP_WRITE, 60,  0, 16'hFFFF, 0,  0, 0, 1, 1);
    plan_word(OP_WRITE, 12, 31, 16'hABCD, 0,  0, 1, 0, 0);
    plan_word(OP_WRITE,  7, 16, 16'h1234, 1,  0, 1, 0, 0);
    // mixed, event triggered: unchanged payload dropped, stuck on first failure
    plan_cfg(REG_STARTUP_TICKS, 16'd0);
    plan_cfg(REG_TX_MODE, MODE_MIXED);
    plan_cfg(REG_PERIOD_MS, 16'd0);
    plan_cfg(REG_TICK_MS, 16'd255);
    plan_cfg(REG_STUCK_LIMIT_MS, 16'd1);
    plan_word(OP_TICK,  0, 0, 16'h0000, 0, 0, 1, 1, 0);
    plan_word(OP_FLUSH, 0, 0, 16'h0000, 0, 0, 1, 1, 1);
    plan_word(OP_TICK,  0, 0, 16'h0000, 0, 0, 1, 1, 0);
    plan_word(OP_WRITE, 0, 8, 16'h005A, 0, 0, 0, 1, 1);
    plan_word(OP_TICK,  0, 0, 16'h0000, 0, 0, 0, 0, 0);
    plan_word(OP_TICK,  0, 0, 16'h0000, 0, 0, 1, 0, 0);
    // periodic, longest period, empty frame
    plan_cfg(REG_HEADER_PROTECTED, 16'd1);
    plan_cfg(REG_TX_MODE, MODE_PERIODIC);
    plan_cfg(REG_PERIOD_MS, 16'hFFFF);
    plan_cfg(REG_TICK_MS, 16'd1);
    plan_cfg(REG_FRAME_LEN, 16'd0);
    plan_word(OP_WRITE, 8, 8, 16'h003C, 0, 0, 1, 1, 1);
    plan_word(OP_TICK,  0, 0, 16'h0000, 0, 0, 1, 0, 0);
    plan_cfg(REG_PERIOD_MS, 16'd1);
    plan_word(OP_TICK,  0, 0, 16'h0000, 0, 0, 1, 0, 0);
    // header-only change is ignored when the header is protected
    plan_cfg(REG_FRAME_LEN, 16'd15);
    plan_cfg(REG_PERIOD_MS, 16'd0);
    plan_cfg(REG_TX_MODE, MODE_MIXED);
    plan_word(OP_WRITE, 8, 8, 16'h00C3, 0, 0, 0, 1, 1);
    plan_word(OP_TICK,  0, 0, 16'h0000, 0, 0, 1, 0, 0);
    plan_cfg(REG_HEADER_PROTECTED, 16'd0);
    plan_word(OP_FLUSH, 0, 0, 16'h0000, 0, 0, 1, 1, 1);
    plan_word(OP_TICK,  0, 0, 16'h0000, 0, 0, 1, 0, 0);
    // short frame, then zero stuck limit and zero tick length
    plan_cfg(REG_FRAME_LEN, 16'd3);
    plan_cfg(REG_TX_MODE, MODE_DIRECT);
    plan_word(OP_WRITE, 20, 12, 16'h0FFF, 1, 0, 1, 0, 0);
    plan_cfg(REG_STUCK_LIMIT_MS, 16'd0);
    plan_cfg(REG_TICK_MS, 16'd0);
    plan_cfg(REG_TX_MODE, MODE_PERIODIC);
    plan_cfg(REG_PERIOD_MS, 16'd0);
    plan_word(OP_WRITE, 16, 5, 16'h0015, 0, 0, 1, 1, 1);
    plan_word(OP_TICK,   0, 0, 16'h0000, 0, 0, 0, 0, 0);
    plan_word(OP_TICK,   0, 0, 16'h0000, 0, 0, 1, 0, 0);
  endfunction

  function automatic logic [15:0] pick_cycle();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return $urandom_range(1, 60);
      2: return 16'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [7:0] pick_tick();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  // ---------------- checking ----------------

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    end
  endfunction

  task automatic check_result();
    res_t e;
    results_seen++;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $error("result word with nothing outstanding");
      return;
    end
    e = results_due.pop_front();
    check_field("sent", e.sent, sent);
    check_field("frame_data", e.frame_data, frame_data);
    check_field("frame_bytes", e.frame_bytes, frame_bytes);
    check_field("stuck", e.stuck, stuck);
    check_field("throttled", e.throttled, throttled);
    check_field("pending_now", e.pending_now, pending_now);
    n_sent += e.sent;
    n_stuck += e.stuck;
    n_throttled += e.throttled;
  endtask

  // Result side: random stalls, one long hold to back the block up
  initial begin : result_side
    int stall;
    bit held;
    held = 0;
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1;
        stall = HOLD_CYCLES;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (stall > 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      check_result();
      @(negedge clk);
    end
  end

  // ---------------- stimulus ----------------

  initial begin : item_side
    item_t w, last_write;
    int pct_ready, r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    op = OP_WRITE;
    bit_pos = '0;
    sig_width = '0;
    sig_value = '0;
    update_enable = 1'b0;
    update_bit_pos = '0;
    link_ready = 1'b0;
    last_write = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    reset_state();

    // directed table
    build_plan();
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_word(plan[i].w, plan[i].typed, idle_res(plan[i].exp_pending));
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 1)
        set_regs(MODE_MIXED, 16'hFFFF, 8'hFF, 16'hFFFF, 4'd8, 1'b0, 16'hFFFF);
      else
        set_regs(phase < 6 ? phase % 4 : $urandom_range(0, 3), pick_cycle(), pick_tick(),
                 $urandom_range(0, 9), $urandom_range(0, 15), $urandom_range(0, 1),
                 pick_limit());
      case (phase % 4)
        0: pct_ready = 100;
        1: pct_ready = 20;
        2: pct_ready = 60;
        default: pct_ready = 90;
      endcase
      tx_idle_on = (phase % 3 != 1);
      rx_idle_on = (phase % 4 != 2);
      repeat (WORDS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        w.op = (r < 45) ? OP_WRITE : (r < 85) ? OP_TICK : (r < 96) ? OP_FLUSH : OP_UNKNOWN;
        w.bit_pos = $urandom_range(0, 63);
        r = $urandom_range(0, 99);
        w.sig_width = (r < 85) ? $urandom_range(1, 16) : (r < 92) ? 5'd0 : $urandom_range(17, 31);
        w.sig_value = $urandom_range(0, 65535);
        w.update_enable = $urandom_range(0, 1);
        w.update_bit_pos = $urandom_range(0, 63);
        w.link_ready = ($urandom_range(0, 99) < pct_ready);
        // rewrite the same signal now and then so event sends see no change
        if (w.op == OP_WRITE) begin
          if ($urandom_range(0, 4) == 0) begin
            w.bit_pos = last_write.bit_pos;
            w.sig_width = last_write.sig_width;
            w.sig_value = last_write.sig_value;
            w.update_enable = 1'b0;
          end
          last_write = w;
        end
        offer_word(w, 0, '0);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Ran %0d words over %0d register settings plus the directed table.",
             words_in, NUM_PHASES);
    $display("Checked %0d results: %0d frames sent, %0d stuck pulses, %0d throttled ticks.",
             results_seen, n_sent, n_stuck, n_throttled);
    if (mismatches == 0)
      $display("[pdu_tx_scheduler_core] OK");
    else
      $display("[pdu_tx_scheduler_core] ERROR");
    $finish;
  end

endmodule
